FILE: hdl/lacrd_pkg.sv
package lacrd_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int DIR_FRAC_DEF    = 14;
   localparam int COORD_FRAC      = 8;
   localparam int BASIS_FRAC      = 24;
   localparam int BASIS_W         = BASIS_FRAC + 2;
   localparam int NORM_W          = 30;
   localparam int SQRT_STEPS      = 31;
   localparam int SQ_W            = 63;
   localparam int CSR_IDX_W       = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_EYE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UP     = 2'd2;

   typedef struct packed {
      logic [2:0][BASIS_W-1:0] bx;
      logic [2:0][BASIS_W-1:0] by;
      logic [2:0][BASIS_W-1:0] bz;
      logic                    ok;
   } basis_type;

   typedef enum logic [3:0] {
      BS_IDLE,
      BS_START,
      BS_XMUL,
      BS_XACC,
      BS_NLOAD,
      BS_NSHIFT,
      BS_SQMUL,
      BS_SQACC,
      BS_SQRT,
      BS_DLOAD,
      BS_DIV,
      BS_DSTORE,
      BS_CYLOAD,
      BS_ROUND
   } bs_state_type;

endpackage

FILE: hdl/look_at_camera_ray_direction.sv
// Look-at camera ray generator.
// Configuration: csr_valid/csr_ready/csr_index/csr_wdata writes the eye point
// (index 0), target point (1) or up vector (2), each three packed Q8.8 values.
// csr_ready is always high. After reset or any write, busy stays high while a
// sequential unit rebuilds the camera basis: one shared multiplier, a
// bit-per-cycle square root and divider; the rebuild stops early, before the
// square root, when the eye sits on the target.
// Requests: a request is taken on a rising edge with start high and busy low.
// Once the basis is ready and while csr_valid is low, one request can be taken every cycle.
// Results: rsp_valid is high for one cycle per request, in request order;
// the pipeline contains a 31-stage square root and a one-bit-per-stage
// divider. The receiver cannot stall, so the pipeline never holds.
// Origin fields carry the eye point. rsp_degenerate flags a zero-length
// vector; the direction is then zero.
// Reset is synchronous: registers return to their reset values, the
// pipeline empties and the basis rebuild starts.
module look_at_camera_ray_direction #(
   parameter int COORD_WIDTH   = lacrd_pkg::COORD_WIDTH_DEF,
   parameter int DIR_FRAC_BITS = lacrd_pkg::DIR_FRAC_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [COORD_WIDTH-1:0]       req_offset_x,
   input  logic signed [COORD_WIDTH-1:0]       req_offset_y,
   input  logic signed [COORD_WIDTH-1:0]       req_offset_z,
   output logic                                rsp_valid,
   output logic signed [COORD_WIDTH-1:0]       rsp_origin_x,
   output logic signed [COORD_WIDTH-1:0]       rsp_origin_y,
   output logic signed [COORD_WIDTH-1:0]       rsp_origin_z,
   output logic signed [DIR_FRAC_BITS+1:0]     rsp_dir_x,
   output logic signed [DIR_FRAC_BITS+1:0]     rsp_dir_y,
   output logic signed [DIR_FRAC_BITS+1:0]     rsp_dir_z,
   output logic                                rsp_degenerate,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lacrd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [3*COORD_WIDTH-1:0]            csr_wdata
);

   localparam int CW = COORD_WIDTH;
   localparam logic [3*CW-1:0] TARGET_RST = (3*CW)'(1) << (2*CW + lacrd_pkg::COORD_FRAC);
   localparam logic [3*CW-1:0] UP_RST     = (3*CW)'(1) << (CW + lacrd_pkg::COORD_FRAC);

   logic [3*CW-1:0] eye_ff, target_ff, up_ff;
   logic            wr;
   logic            basis_busy;
   lacrd_pkg::basis_type basis;
   logic signed [CW-1:0] req_w [3];
   logic signed [DIR_FRAC_BITS+1:0] dir [3];

   assign csr_ready = 1'b1;
   assign wr        = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         eye_ff    <= '0;
         target_ff <= TARGET_RST;
         up_ff     <= UP_RST;
      end else if (wr) begin
         case (csr_index)
            lacrd_pkg::CSR_EYE:    eye_ff    <= csr_wdata;
            lacrd_pkg::CSR_TARGET: target_ff <= csr_wdata;
            lacrd_pkg::CSR_UP:     up_ff     <= csr_wdata;
            default:               eye_ff    <= eye_ff;
         endcase
      end
   end

   lacrd_basis #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_basis (
      .clock  (clock),
      .reset  (reset),
      .kick   (wr),
      .eye    (eye_ff),
      .target (target_ff),
      .up     (up_ff),
      .busy   (basis_busy),
      .basis  (basis)
   );

   assign busy = basis_busy || csr_valid;

   assign req_w[0] = req_offset_x;
   assign req_w[1] = req_offset_y;
   assign req_w[2] = req_offset_z;

   lacrd_dir_pipe #(
      .COORD_WIDTH   (COORD_WIDTH),
      .DIR_FRAC_BITS (DIR_FRAC_BITS)
   ) u_pipe (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (start && !busy),
      .in_w           (req_w),
      .basis          (basis),
      .out_valid      (rsp_valid),
      .out_dir        (dir),
      .out_degenerate (rsp_degenerate)
   );

   assign rsp_dir_x    = dir[0];
   assign rsp_dir_y    = dir[1];
   assign rsp_dir_z    = dir[2];
   assign rsp_origin_x = signed'(eye_ff[CW-1:0]);
   assign rsp_origin_y = signed'(eye_ff[2*CW-1:CW]);
   assign rsp_origin_z = signed'(eye_ff[3*CW-1:2*CW]);

endmodule

FILE: hdl/lacrd_basis.sv
module lacrd_basis #(
   parameter int COORD_WIDTH = lacrd_pkg::COORD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         kick,
   input  logic [3*COORD_WIDTH-1:0]     eye,
   input  logic [3*COORD_WIDTH-1:0]     target,
   input  logic [3*COORD_WIDTH-1:0]     up,
   output logic                         busy,
   output lacrd_pkg::basis_type         basis
);

   localparam int CW  = COORD_WIDTH;
   localparam int DW  = CW + 1;
   localparam int OPW = (CW + 1 > lacrd_pkg::NORM_W + 1) ? CW + 1 : lacrd_pkg::NORM_W + 1;
   localparam int PRW = 2 * OPW;
   localparam int ACW = PRW + 1;
   localparam int BF  = lacrd_pkg::BASIS_FRAC;
   localparam int BW  = lacrd_pkg::BASIS_W;
   localparam int NW  = lacrd_pkg::NORM_W;
   localparam int SQW = lacrd_pkg::SQ_W;
   localparam int DVW = NW + BF + 2;
   localparam int KW  = $clog2(BF + 1);
   localparam logic [BF:0]    QLIM    = {1'b1, {BF{1'b0}}};
   localparam logic [SQW-1:0] SBIT0   = SQW'(1) << (2 * (lacrd_pkg::SQRT_STEPS - 1));

   lacrd_pkg::bs_state_type state_ff, state_in;

   logic signed [DW-1:0]  d_ff [3], d_in [3];
   logic signed [OPW-1:0] opa_ff [3], opa_in [3];
   logic signed [OPW-1:0] opb_ff [3], opb_in [3];
   logic [2:0]            step_ff, step_in;
   logic                  cyph_ff, cyph_in;
   logic signed [PRW-1:0] prod_ff, prod_in;
   logic signed [ACW-1:0] acc_ff, acc_in;
   logic signed [ACW-1:0] cross_ff [3], cross_in [3];
   logic [ACW-1:0]        mag_ff [3], mag_in [3];
   logic                  neg_ff [3], neg_in [3];
   logic                  which_ff, which_in;
   logic                  ok_ff, ok_in;
   logic [SQW-1:0]        srem_ff, srem_in;
   logic [SQW-1:0]        sres_ff, sres_in;
   logic [SQW-1:0]        sbit_ff, sbit_in;
   logic [1:0]            comp_ff, comp_in;
   logic [DVW-1:0]        drem_ff, drem_in;
   logic [DVW-1:0]        ddiv_ff, ddiv_in;
   logic [BF:0]           q_ff, q_in;
   logic [KW-1:0]         k_ff, k_in;
   logic signed [BW-1:0]  bz_ff [3], bz_in [3];
   logic signed [BW-1:0]  bx_ff [3], bx_in [3];
   logic signed [BW-1:0]  by_ff [3], by_in [3];

   logic signed [DW-1:0]  dn [3];
   logic signed [ACW-1:0] src [3];
   logic [ACW-1:0]        ld_mag [3];
   logic                  ld_neg [3];
   logic                  ld_zero;
   logic [ACW-1:0]        mmax;
   logic                  big, tiny;
   logic [1:0]            ia, ib;
   logic signed [OPW-1:0] mul_a, mul_b;
   logic signed [ACW-1:0] prod_ext;
   logic [SQW-1:0]        sq_try;
   logic                  sq_ge;
   logic                  dv_ge;
   logic [BF:0]           qc;
   logic signed [BW-1:0]  qs;
   logic [ACW-1:0]        rmag [3];
   logic [ACW-1:0]        rnd [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dn[i]     = DW'(signed'(target[i*CW +: CW])) - DW'(signed'(eye[i*CW +: CW]));
         src[i]    = which_ff ? cross_ff[i] : ACW'(d_ff[i]);
         ld_neg[i] = src[i][ACW-1];
         ld_mag[i] = ld_neg[i] ? unsigned'(-src[i]) : unsigned'(src[i]);
         rmag[i]   = cross_ff[i][ACW-1] ? unsigned'(-cross_ff[i]) : unsigned'(cross_ff[i]);
         rnd[i]    = (rmag[i] + (ACW'(1) << (BF - 1))) >> BF;
      end
      ld_zero = (ld_mag[0] == '0) && (ld_mag[1] == '0) && (ld_mag[2] == '0);
      mmax = mag_ff[0];
      if (mag_ff[1] > mmax) begin
         mmax = mag_ff[1];
      end
      if (mag_ff[2] > mmax) begin
         mmax = mag_ff[2];
      end
      big  = |mmax[ACW-1:NW];
      tiny = ~|mmax[ACW-1:NW-1];
      case (step_ff)
         3'd0: begin ia = 2'd1; ib = 2'd2; end
         3'd1: begin ia = 2'd2; ib = 2'd1; end
         3'd2: begin ia = 2'd2; ib = 2'd0; end
         3'd3: begin ia = 2'd0; ib = 2'd2; end
         3'd4: begin ia = 2'd0; ib = 2'd1; end
         3'd5: begin ia = 2'd1; ib = 2'd0; end
         default: begin ia = 2'd0; ib = 2'd0; end
      endcase
      if (state_ff == lacrd_pkg::BS_SQMUL) begin
         mul_a = signed'({{(OPW-NW){1'b0}}, mag_ff[step_ff[1:0]][NW-1:0]});
         mul_b = mul_a;
      end else begin
         mul_a = opa_ff[ia];
         mul_b = opb_ff[ib];
      end
      prod_ext = ACW'(prod_ff);
      sq_try   = sres_ff + sbit_ff;
      sq_ge    = srem_ff >= sq_try;
      dv_ge    = drem_ff >= ddiv_ff;
      qc       = (q_ff > QLIM) ? QLIM : q_ff;
      qs       = neg_ff[comp_ff] ? -signed'({1'b0, qc}) : signed'({1'b0, qc});
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lacrd_pkg::BS_IDLE:   state_in = lacrd_pkg::BS_IDLE;
         lacrd_pkg::BS_START:  state_in = lacrd_pkg::BS_XMUL;
         lacrd_pkg::BS_XMUL:   state_in = lacrd_pkg::BS_XACC;
         lacrd_pkg::BS_XACC: begin
            if (step_ff != 3'd5) begin
               state_in = lacrd_pkg::BS_XMUL;
            end else if (cyph_ff) begin
               state_in = lacrd_pkg::BS_ROUND;
            end else begin
               state_in = lacrd_pkg::BS_NLOAD;
            end
         end
         lacrd_pkg::BS_NLOAD:  state_in = ld_zero ? lacrd_pkg::BS_IDLE : lacrd_pkg::BS_NSHIFT;
         lacrd_pkg::BS_NSHIFT: state_in = (big || tiny) ? lacrd_pkg::BS_NSHIFT
                                                        : lacrd_pkg::BS_SQMUL;
         lacrd_pkg::BS_SQMUL:  state_in = lacrd_pkg::BS_SQACC;
         lacrd_pkg::BS_SQACC:  state_in = (step_ff == 3'd2) ? lacrd_pkg::BS_SQRT
                                                            : lacrd_pkg::BS_SQMUL;
         lacrd_pkg::BS_SQRT:   state_in = sbit_ff[0] ? lacrd_pkg::BS_DLOAD : lacrd_pkg::BS_SQRT;
         lacrd_pkg::BS_DLOAD:  state_in = lacrd_pkg::BS_DIV;
         lacrd_pkg::BS_DIV:    state_in = (k_ff == '0) ? lacrd_pkg::BS_DSTORE : lacrd_pkg::BS_DIV;
         lacrd_pkg::BS_DSTORE: begin
            if (comp_ff != 2'd2) begin
               state_in = lacrd_pkg::BS_DLOAD;
            end else if (!which_ff) begin
               state_in = lacrd_pkg::BS_NLOAD;
            end else begin
               state_in = lacrd_pkg::BS_CYLOAD;
            end
         end
         lacrd_pkg::BS_CYLOAD: state_in = lacrd_pkg::BS_XMUL;
         lacrd_pkg::BS_ROUND:  state_in = lacrd_pkg::BS_IDLE;
         default:              state_in = lacrd_pkg::BS_IDLE;
      endcase
      if (kick) begin
         state_in = lacrd_pkg::BS_START;
      end
   end

   always_comb begin
      d_in     = d_ff;
      opa_in   = opa_ff;
      opb_in   = opb_ff;
      step_in  = step_ff;
      cyph_in  = cyph_ff;
      prod_in  = mul_a * mul_b;
      acc_in   = acc_ff;
      cross_in = cross_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      which_in = which_ff;
      ok_in    = ok_ff;
      srem_in  = srem_ff;
      sres_in  = sres_ff;
      sbit_in  = sbit_ff;
      comp_in  = comp_ff;
      drem_in  = drem_ff;
      ddiv_in  = ddiv_ff;
      q_in     = q_ff;
      k_in     = k_ff;
      bz_in    = bz_ff;
      bx_in    = bx_ff;
      by_in    = by_ff;
      case (state_ff)
         lacrd_pkg::BS_START: begin
            for (int i = 0; i < 3; i++) begin
               d_in[i]   = dn[i];
               opa_in[i] = OPW'(signed'(up[i*CW +: CW]));
               opb_in[i] = OPW'(dn[i]);
            end
            step_in  = '0;
            cyph_in  = 1'b0;
            which_in = 1'b0;
            ok_in    = 1'b1;
         end
         lacrd_pkg::BS_XACC: begin
            if (!step_ff[0]) begin
               acc_in = prod_ext;
            end else begin
               cross_in[step_ff[2:1]] = acc_ff - prod_ext;
            end
            step_in = step_ff + 3'd1;
         end
         lacrd_pkg::BS_NLOAD: begin
            if (ld_zero) begin
               ok_in = 1'b0;
            end
            mag_in = ld_mag;
            neg_in = ld_neg;
         end
         lacrd_pkg::BS_NSHIFT: begin
            for (int i = 0; i < 3; i++) begin
               if (big) begin
                  mag_in[i] = mag_ff[i] >> 1;
               end else if (tiny) begin
                  mag_in[i] = mag_ff[i] << 1;
               end
            end
            step_in = '0;
            acc_in  = '0;
         end
         lacrd_pkg::BS_SQACC: begin
            acc_in  = acc_ff + prod_ext;
            step_in = step_ff + 3'd1;
            srem_in = SQW'(unsigned'(acc_ff + prod_ext));
            sres_in = '0;
            sbit_in = SBIT0;
         end
         lacrd_pkg::BS_SQRT: begin
            if (sq_ge) begin
               srem_in = srem_ff - sq_try;
               sres_in = (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_in = sres_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            comp_in = '0;
         end
         lacrd_pkg::BS_DLOAD: begin
            drem_in = ({{(DVW-NW){1'b0}}, mag_ff[comp_ff][NW-1:0]} << BF)
                      + {{(DVW-NW){1'b0}}, sres_ff[NW:1]};
            ddiv_in = {{(DVW-NW-1-BF){1'b0}}, sres_ff[NW:0], {BF{1'b0}}};
            q_in    = '0;
            k_in    = KW'(BF);
         end
         lacrd_pkg::BS_DIV: begin
            if (dv_ge) begin
               drem_in = drem_ff - ddiv_ff;
            end
            q_in    = {q_ff[BF-1:0], dv_ge};
            ddiv_in = ddiv_ff >> 1;
            k_in    = k_ff - KW'(1);
         end
         lacrd_pkg::BS_DSTORE: begin
            if (which_ff) begin
               bx_in[comp_ff] = qs;
            end else begin
               bz_in[comp_ff] = qs;
            end
            comp_in = comp_ff + 2'd1;
            if (comp_ff == 2'd2) begin
               which_in = 1'b1;
            end
         end
         lacrd_pkg::BS_CYLOAD: begin
            for (int i = 0; i < 3; i++) begin
               opa_in[i] = OPW'(bz_ff[i]);
               opb_in[i] = OPW'(bx_ff[i]);
            end
            step_in = '0;
            cyph_in = 1'b1;
         end
         lacrd_pkg::BS_ROUND: begin
            for (int i = 0; i < 3; i++) begin
               by_in[i] = cross_ff[i][ACW-1] ? -signed'(rnd[i][BW-1:0])
                                             : signed'(rnd[i][BW-1:0]);
            end
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lacrd_pkg::BS_START;
      end else begin
         state_ff <= state_in;
      end
      d_ff     <= d_in;
      opa_ff   <= opa_in;
      opb_ff   <= opb_in;
      step_ff  <= step_in;
      cyph_ff  <= cyph_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      cross_ff <= cross_in;
      mag_ff   <= mag_in;
      neg_ff   <= neg_in;
      which_ff <= which_in;
      ok_ff    <= ok_in;
      srem_ff  <= srem_in;
      sres_ff  <= sres_in;
      sbit_ff  <= sbit_in;
      comp_ff  <= comp_in;
      drem_ff  <= drem_in;
      ddiv_ff  <= ddiv_in;
      q_ff     <= q_in;
      k_ff     <= k_in;
      bz_ff    <= bz_in;
      bx_ff    <= bx_in;
      by_ff    <= by_in;
   end

   assign busy = (state_ff != lacrd_pkg::BS_IDLE);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         basis.bx[i] = unsigned'(bx_ff[i]);
         basis.by[i] = unsigned'(by_ff[i]);
         basis.bz[i] = unsigned'(bz_ff[i]);
      end
      basis.ok = ok_ff;
   end

endmodule

FILE: hdl/lacrd_dir_pipe.sv
module lacrd_dir_pipe #(
   parameter int COORD_WIDTH   = lacrd_pkg::COORD_WIDTH_DEF,
   parameter int DIR_FRAC_BITS = lacrd_pkg::DIR_FRAC_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic signed [COORD_WIDTH-1:0]   in_w [3],
   input  lacrd_pkg::basis_type            basis,
   output logic                            out_valid,
   output logic signed [DIR_FRAC_BITS+1:0] out_dir [3],
   output logic                            out_degenerate
);

   localparam int CW    = COORD_WIDTH;
   localparam int F     = DIR_FRAC_BITS;
   localparam int BW    = lacrd_pkg::BASIS_W;
   localparam int PW    = CW + BW;
   localparam int SW    = PW + 2;
   localparam int MW    = SW;
   localparam int NSH   = $clog2(MW);
   localparam int NW    = lacrd_pkg::NORM_W;
   localparam int SQW   = lacrd_pkg::SQ_W;
   localparam int STEPS = lacrd_pkg::SQRT_STEPS;
   localparam int NUMW  = NW + F + 2;
   localparam int OW    = F + 2;
   localparam logic [F:0] QLIM = {1'b1, {F{1'b0}}};

   // input register
   logic                 v0_ff;
   logic signed [CW-1:0] w0_ff [3];

   // weighted products
   logic                 v1_ff;
   logic signed [PW-1:0] p1_ff [3][3], p1_in [3][3];

   // weighted sum
   logic                 v2_ff;
   logic signed [SW-1:0] s2_ff [3], s2_in [3];

   // magnitude
   logic                 v3_ff, dg3_in, dg3_ff;
   logic [MW-1:0]        mag3_ff [3], mag3_in [3];
   logic                 neg3_ff [3];

   // normalize shift chain, entry 0 holds the max stage
   logic                 nv_ff  [NSH+1];
   logic                 ndg_ff [NSH+1];
   logic [MW-1:0]        nm_ff  [NSH+1];
   logic [MW-1:0]        nmag_ff [NSH+1][3];
   logic                 nneg_ff [NSH+1][3];
   logic [MW-1:0]        m4_in;

   // squares
   logic                 vq_ff, dgq_ff;
   logic [NW-1:0]        nq_ff [3];
   logic [2*NW-1:0]      sq_ff [3];
   logic                 negq_ff [3];

   // square root chain, entry 0 holds the sum of squares
   logic                 rv_ff   [STEPS+1];
   logic                 rdg_ff  [STEPS+1];
   logic [SQW-1:0]       rrem_ff [STEPS+1];
   logic [SQW-1:0]       rres_ff [STEPS+1];
   logic [NW-1:0]        rn_ff   [STEPS+1][3];
   logic                 rneg_ff [STEPS+1][3];

   // division chain, entry 0 holds the numerators
   logic                 dv_ff   [F+2];
   logic                 ddg_ff  [F+2];
   logic [NW:0]          dr_ff   [F+2];
   logic [NUMW-1:0]      drem_ff [F+2][3];
   logic [F:0]           dq_ff   [F+2][3];
   logic                 dneg_ff [F+2][3];

   logic                 vo_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_in[i][0] = w0_ff[0] * signed'(basis.bx[i]);
         p1_in[i][1] = w0_ff[1] * signed'(basis.by[i]);
         p1_in[i][2] = w0_ff[2] * signed'(basis.bz[i]);
         s2_in[i] = SW'(p1_ff[i][0]) + SW'(p1_ff[i][1]) + SW'(p1_ff[i][2]);
         mag3_in[i] = s2_ff[i][SW-1] ? unsigned'(-s2_ff[i]) : unsigned'(s2_ff[i]);
      end
      dg3_in = !basis.ok || ((s2_ff[0] == '0) && (s2_ff[1] == '0) && (s2_ff[2] == '0));
      m4_in = mag3_ff[0];
      if (mag3_ff[1] > m4_in) begin
         m4_in = mag3_ff[1];
      end
      if (mag3_ff[2] > m4_in) begin
         m4_in = mag3_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff     <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         nv_ff[0]  <= 1'b0;
         vq_ff     <= 1'b0;
         rv_ff[0]  <= 1'b0;
         dv_ff[0]  <= 1'b0;
         vo_ff     <= 1'b0;
      end else begin
         v0_ff     <= in_valid;
         v1_ff     <= v0_ff;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         nv_ff[0]  <= v3_ff;
         vq_ff     <= nv_ff[NSH];
         rv_ff[0]  <= vq_ff;
         dv_ff[0]  <= rv_ff[STEPS];
         vo_ff     <= dv_ff[F+1];
      end
      w0_ff  <= in_w;
      p1_ff  <= p1_in;
      s2_ff  <= s2_in;
      mag3_ff <= mag3_in;
      dg3_ff  <= dg3_in;
      for (int i = 0; i < 3; i++) begin
         neg3_ff[i] <= s2_ff[i][SW-1];
      end
      nm_ff[0]   <= m4_in;
      ndg_ff[0]  <= dg3_ff;
      nmag_ff[0] <= mag3_ff;
      nneg_ff[0] <= neg3_ff;
      dgq_ff <= ndg_ff[NSH];
      for (int i = 0; i < 3; i++) begin
         nq_ff[i]   <= nmag_ff[NSH][i][MW-1 -: NW];
         sq_ff[i]   <= nmag_ff[NSH][i][MW-1 -: NW] * nmag_ff[NSH][i][MW-1 -: NW];
         negq_ff[i] <= nneg_ff[NSH][i];
      end
      rrem_ff[0] <= SQW'(sq_ff[0]) + SQW'(sq_ff[1]) + SQW'(sq_ff[2]);
      rres_ff[0] <= '0;
      rdg_ff[0]  <= dgq_ff;
      rn_ff[0]   <= nq_ff;
      rneg_ff[0] <= negq_ff;
      dr_ff[0]   <= rres_ff[STEPS][NW:0];
      ddg_ff[0]  <= rdg_ff[STEPS];
      for (int i = 0; i < 3; i++) begin
         drem_ff[0][i] <= (NUMW'(rn_ff[STEPS][i]) << F) + NUMW'(rres_ff[STEPS][NW:1]);
         dq_ff[0][i]   <= '0;
         dneg_ff[0][i] <= rneg_ff[STEPS][i];
      end
   end

   for (genvar g = 0; g < NSH; g++) begin : g_norm
      localparam int K = 2 ** (NSH - 1 - g);
      logic hit;
      assign hit = (nm_ff[g][MW-1 -: K] == '0);
      always_ff @(posedge clock) begin
         if (reset) begin
            nv_ff[g+1] <= 1'b0;
         end else begin
            nv_ff[g+1] <= nv_ff[g];
         end
         ndg_ff[g+1]  <= ndg_ff[g];
         nneg_ff[g+1] <= nneg_ff[g];
         nm_ff[g+1]   <= hit ? (nm_ff[g] << K) : nm_ff[g];
         for (int i = 0; i < 3; i++) begin
            nmag_ff[g+1][i] <= hit ? (nmag_ff[g][i] << K) : nmag_ff[g][i];
         end
      end
   end

   for (genvar g = 0; g < STEPS; g++) begin : g_sqrt
      localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (STEPS - 1 - g));
      logic [SQW-1:0] try_v;
      logic           ge;
      assign try_v = rres_ff[g] + BIT;
      assign ge    = rrem_ff[g] >= try_v;
      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[g+1] <= 1'b0;
         end else begin
            rv_ff[g+1] <= rv_ff[g];
         end
         rdg_ff[g+1]  <= rdg_ff[g];
         rn_ff[g+1]   <= rn_ff[g];
         rneg_ff[g+1] <= rneg_ff[g];
         rrem_ff[g+1] <= ge ? (rrem_ff[g] - try_v) : rrem_ff[g];
         rres_ff[g+1] <= ge ? ((rres_ff[g] >> 1) + BIT) : (rres_ff[g] >> 1);
      end
   end

   for (genvar g = 0; g <= F; g++) begin : g_div
      logic [NUMW-1:0] dvs;
      logic            ge [3];
      assign dvs = NUMW'(dr_ff[g]) << (F - g);
      always_comb begin
         for (int i = 0; i < 3; i++) begin
            ge[i] = drem_ff[g][i] >= dvs;
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[g+1] <= 1'b0;
         end else begin
            dv_ff[g+1] <= dv_ff[g];
         end
         ddg_ff[g+1]  <= ddg_ff[g];
         dr_ff[g+1]   <= dr_ff[g];
         dneg_ff[g+1] <= dneg_ff[g];
         for (int i = 0; i < 3; i++) begin
            drem_ff[g+1][i] <= ge[i] ? (drem_ff[g][i] - dvs) : drem_ff[g][i];
            dq_ff[g+1][i]   <= {dq_ff[g][i][F-1:0], ge[i]};
         end
      end
   end

   logic [F:0]           qc [3];
   logic signed [OW-1:0] dir_in [3];
   logic signed [OW-1:0] dir_ff [3];
   logic                 dgo_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         qc[i] = (dq_ff[F+1][i] > QLIM) ? QLIM : dq_ff[F+1][i];
         if (ddg_ff[F+1]) begin
            dir_in[i] = '0;
         end else if (dneg_ff[F+1][i]) begin
            dir_in[i] = -signed'({1'b0, qc[i]});
         end else begin
            dir_in[i] = signed'({1'b0, qc[i]});
         end
      end
   end

   always_ff @(posedge clock) begin
      dir_ff <= dir_in;
      dgo_ff <= ddg_ff[F+1];
   end

   assign out_valid      = vo_ff;
   assign out_dir        = dir_ff;
   assign out_degenerate = dgo_ff;

endmodule

FILE: dv/look_at_camera_ray_direction_test.sv
module look_at_camera_ray_direction_test;

   localparam int W = lacrd_pkg::COORD_WIDTH_DEF;
   localparam int DF = lacrd_pkg::DIR_FRAC_DEF;
   localparam logic [lacrd_pkg::CSR_IDX_W-1:0] CSR_NONE = 2'd3;
   localparam int DRAIN_CYCLES = 90;
   localparam int CYCLE_LIMIT = 400000;

   typedef longint vec3_type [3];

   typedef struct {
      logic [W-1:0]  ox, oy, oz;
      logic [DF+1:0] dx, dy, dz;
      logic          degen;
   } ray_type;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [W-1:0] req_offset_x = 0, req_offset_y = 0, req_offset_z = 0;
   logic rsp_valid;
   logic signed [W-1:0] rsp_origin_x, rsp_origin_y, rsp_origin_z;
   logic signed [DF+1:0] rsp_dir_x, rsp_dir_y, rsp_dir_z;
   logic rsp_degenerate;
   logic csr_valid = 0;
   logic csr_ready;
   logic [lacrd_pkg::CSR_IDX_W-1:0] csr_index = lacrd_pkg::CSR_EYE;
   logic [3*W-1:0] csr_wdata = 0;

   logic [3*W-1:0] eye_reg, target_reg, up_reg;
   ray_type pending_rays[$];
   int errors = 0;
   int cycles = 0;

   look_at_camera_ray_direction u_dut (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic longint unsigned int_sqrt(input longint unsigned s);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= res + bitv) begin
            s -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic bit unit_vec(input vec3_type v, input int f, output vec3_type u);
      longint unsigned mag[3];
      longint unsigned m, s, r, q, lim;
      bit neg[3];
      m = 0;
      s = 0;
      lim = 64'd1 << f;
      for (int i = 0; i < 3; i++) begin
         neg[i] = v[i] < 0;
         mag[i] = neg[i] ? -v[i] : v[i];
         if (mag[i] > m) m = mag[i];
      end
      u = '{0, 0, 0};
      if (m == 0) return 0;
      while (m >= (64'd1 << 30)) begin
         m >>= 1;
         for (int i = 0; i < 3; i++) mag[i] >>= 1;
      end
      while (m < (64'd1 << 29)) begin
         m <<= 1;
         for (int i = 0; i < 3; i++) mag[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
      r = int_sqrt(s);
      for (int i = 0; i < 3; i++) begin
         q = ((mag[i] << f) + (r >> 1)) / r;
         if (q > lim) q = lim;
         u[i] = neg[i] ? -longint'(q) : longint'(q);
      end
      return 1;
   endfunction

   function automatic vec3_type cross_vec(input vec3_type a, input vec3_type b);
      vec3_type c;
      c[0] = a[1] * b[2] - a[2] * b[1];
      c[1] = a[2] * b[0] - a[0] * b[2];
      c[2] = a[0] * b[1] - a[1] * b[0];
      return c;
   endfunction

   function automatic longint round_shift(input longint p, input int n);
      longint unsigned m;
      m = (p < 0) ? -p : p;
      m = (m + (64'd1 << (n - 1))) >> n;
      return (p < 0) ? -longint'(m) : longint'(m);
   endfunction

   function automatic vec3_type split_coords(input logic [3*W-1:0] r);
      vec3_type c;
      for (int i = 0; i < 3; i++) c[i] = $signed(r[i*W +: W]);
      return c;
   endfunction

   function automatic ray_type predict_ray(input logic signed [W-1:0] wx, wy, wz);
      vec3_type e, t, up, d, bx, by, bz, cx, cy, sum, dir;
      longint wt[3];
      bit ok;
      ray_type r;
      e = split_coords(eye_reg);
      t = split_coords(target_reg);
      up = split_coords(up_reg);
      wt[0] = wx;
      wt[1] = wy;
      wt[2] = wz;
      for (int i = 0; i < 3; i++) d[i] = t[i] - e[i];
      dir = '{0, 0, 0};
      ok = unit_vec(d, lacrd_pkg::BASIS_FRAC, bz);
      cx = cross_vec(up, d);
      ok = unit_vec(cx, lacrd_pkg::BASIS_FRAC, bx) && ok;
      if (ok) begin
         cy = cross_vec(bz, bx);
         for (int i = 0; i < 3; i++) by[i] = round_shift(cy[i], lacrd_pkg::BASIS_FRAC);
         for (int i = 0; i < 3; i++) sum[i] = wt[0] * bx[i] + wt[1] * by[i] + wt[2] * bz[i];
         ok = unit_vec(sum, DF, dir);
      end
      if (!ok) dir = '{0, 0, 0};
      r.ox = W'(e[0]);
      r.oy = W'(e[1]);
      r.oz = W'(e[2]);
      r.dx = (DF+2)'(dir[0]);
      r.dy = (DF+2)'(dir[1]);
      r.dz = (DF+2)'(dir[2]);
      r.degen = !ok;
      return r;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got, exp_v);
      $display("mismatch %s: got %h expected %h at cycle %0d", field, got, exp_v, cycles);
      errors++;
   endtask

   always @(negedge clock) begin
      ray_type e;
      if (!reset && rsp_valid) begin
         if (pending_rays.size() == 0) begin
            report_mismatch("rsp_valid", 32'd1, 32'd0);
         end else begin
            e = pending_rays.pop_front();
            if (rsp_origin_x !== e.ox) report_mismatch("origin_x", rsp_origin_x, e.ox);
            if (rsp_origin_y !== e.oy) report_mismatch("origin_y", rsp_origin_y, e.oy);
            if (rsp_origin_z !== e.oz) report_mismatch("origin_z", rsp_origin_z, e.oz);
            if (rsp_dir_x !== e.dx) report_mismatch("dir_x", rsp_dir_x, e.dx);
            if (rsp_dir_y !== e.dy) report_mismatch("dir_y", rsp_dir_y, e.dy);
            if (rsp_dir_z !== e.dz) report_mismatch("dir_z", rsp_dir_z, e.dz);
            if (rsp_degenerate !== e.degen)
               report_mismatch("degenerate", rsp_degenerate, e.degen);
         end
      end
   end

   // start stays high across back-to-back requests
   task automatic send_request(input logic [W-1:0] wx, wy, wz, input bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
      start <= 1;
      req_offset_x <= wx;
      req_offset_y <= wy;
      req_offset_z <= wz;
      do @(negedge clock); while (busy);
      @(posedge clock);
      pending_rays.push_back(predict_ray(wx, wy, wz));
   endtask

   task automatic wait_idle();
      start <= 0;
      while (pending_rays.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [lacrd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [3*W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(negedge clock); while (!csr_ready);
      @(posedge clock);
      csr_valid <= 0;
      case (idx)
         lacrd_pkg::CSR_EYE: eye_reg = val;
         lacrd_pkg::CSR_TARGET: target_reg = val;
         lacrd_pkg::CSR_UP: up_reg = val;
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic set_camera(input logic [3*W-1:0] e, t, u);
      wait_idle();
      write_csr(lacrd_pkg::CSR_EYE, e);
      write_csr(lacrd_pkg::CSR_TARGET, t);
      write_csr(lacrd_pkg::CSR_UP, u);
   endtask

   function automatic logic [3*W-1:0] pack3(input logic [W-1:0] x, y, z);
      return {z, y, x};
   endfunction

   function automatic logic [W-1:0] rand_weight();
      case ($urandom_range(0, 3))
         0: return W'($urandom_range(0, 1023) - 512);
         1: return $urandom_range(0, 7) == 0 ? 16'h8000 : 16'h7fff;
         default: return W'($urandom);
      endcase
   endfunction

   task automatic test_reset_defaults();
      send_request(16'h0100, 16'h0000, 16'h0000);
      send_request(16'h0000, 16'h0100, 16'h0000);
      send_request(16'h0000, 16'h0000, 16'h0100, 1);
      send_request(16'h7fff, 16'h8000, 16'h7fff, 1);
   endtask

   task automatic test_directed();
      set_camera(pack3(16'h8000, 16'h8000, 16'h8000),
                 pack3(16'h7fff, 16'h7fff, 16'h7fff),
                 pack3(16'h0000, 16'h7fff, 16'h0000));
      send_request(16'h8000, 16'h8000, 16'h8000);
      send_request(16'h7fff, 16'h7fff, 16'h7fff, 1);
      send_request(16'h0001, 16'hffff, 16'h0001);
      send_request(16'h0000, 16'h0000, 16'h0000);
      set_camera(pack3(16'h7fff, 16'h8000, 16'h0000),
                 pack3(16'h8000, 16'h7fff, 16'h0001),
                 pack3(16'h8000, 16'h8000, 16'h8000));
      send_request(16'h8000, 16'h7fff, 16'h0000);
      send_request(16'h0100, 16'hff00, 16'h0080, 1);
      wait_idle();
      write_csr(CSR_NONE, 48'hffff_ffff_ffff);
      send_request(16'h1234, 16'hedcb, 16'h0101);
   endtask

   task automatic test_degenerate();
      // eye on target
      set_camera(pack3(16'h0123, 16'hfe00, 16'h0040),
                 pack3(16'h0123, 16'hfe00, 16'h0040),
                 pack3(16'h0000, 16'h0100, 16'h0000));
      send_request(16'h0100, 16'h0100, 16'h0100);
      // up parallel to view
      set_camera(pack3(16'h0000, 16'h0000, 16'h0000),
                 pack3(16'h0000, 16'h0200, 16'h0000),
                 pack3(16'h0000, 16'hff00, 16'h0000));
      send_request(16'h0100, 16'h0100, 16'h0100);
      // zero up
      wait_idle();
      write_csr(lacrd_pkg::CSR_UP, 48'h0);
      send_request(16'h0100, 16'h0000, 16'h0000);
      // valid basis, zero weights, then a one-LSB z weight
      wait_idle();
      write_csr(lacrd_pkg::CSR_UP, pack3(16'h0000, 16'h0100, 16'h0000));
      write_csr(lacrd_pkg::CSR_TARGET, pack3(16'h0000, 16'h0000, 16'h0100));
      send_request(16'h0000, 16'h0000, 16'h0000);
      send_request(16'h0000, 16'h0000, 16'h0001, 1);
   endtask

   task automatic test_random();
      logic [3*W-1:0] e, t, u;
      for (int phase = 0; phase < 7; phase++) begin
         case (phase % 3)
            0: begin
               e = (3*W)'({$urandom, $urandom});
               t = (3*W)'({$urandom, $urandom});
               u = (3*W)'({$urandom, $urandom});
            end
            1: begin
               e = pack3(W'($urandom_range(0, 255) - 128), W'($urandom_range(0, 255) - 128),
                         W'($urandom_range(0, 255) - 128));
               t = pack3(W'($urandom_range(0, 4095) - 2048),
                         W'($urandom_range(0, 4095) - 2048),
                         W'($urandom_range(0, 4095) - 2048));
               u = pack3(W'($urandom_range(0, 3) - 1), 16'h0100,
                         W'($urandom_range(0, 3) - 1));
            end
            default: begin
               e = pack3(16'h0000, 16'h0000, 16'h0000);
               t = pack3(W'($urandom), W'($urandom), W'($urandom));
               u = ($urandom_range(0, 3) == 0) ? t : pack3(16'h0000, 16'h0100, 16'h0000);
            end
         endcase
         set_camera(e, t, u);
         for (int n = 0; n < 100; n++)
            send_request(rand_weight(), rand_weight(), rand_weight(),
                         $urandom_range(0, 2) == 0);
      end
   endtask

   initial begin
      eye_reg = 48'h0;
      target_reg = 48'h0100_0000_0000;
      up_reg = 48'h0000_0100_0000;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_reset_defaults();
      test_directed();
      test_degenerate();
      test_random();
      wait_idle();
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/lacrd_pkg.sv
hdl/lacrd_basis.sv
hdl/lacrd_dir_pipe.sv
hdl/look_at_camera_ray_direction.sv
dv/look_at_camera_ray_direction_test.sv
